FILE: rtl/lzw_variable_width_decoder_assert.svh
// Assertion macros for the LZW decoder.
// Depends on nothing; the including module supplies clk and rst.
`ifndef LZW_VARIABLE_WIDTH_DECODER_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_DECODER_ASSERT_SVH

// Same-cycle implication, silent during reset
`define LVWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, silent during reset
`define LVWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lzwvwd_pkg.sv
// Shared types and constants for the LZW decoder.
// No dependencies.
package lzwvwd_pkg;

  localparam int DICT_ENTRIES_DEF = 8192;
  localparam int STACK_DEPTH_DEF  = 8192;

  localparam logic [12:0] CODE_CLEAR  = 13'h100;
  localparam logic [12:0] CODE_END    = 13'h101;
  localparam logic [13:0] FIRST_FREE  = 14'h102;
  localparam logic [13:0] FIRST_LIMIT = 14'h200;
  localparam logic [3:0]  MAX_WIDTH   = 4'hD;
  localparam logic [3:0]  START_WIDTH = 4'd9;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [2:0] ST_BYTE    = 3'd0;
  localparam logic [2:0] ST_NEED    = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_FED     = 3'd3;
  localparam logic [2:0] ST_REFUSED = 3'd4;

  // Register slot selected by paddr[2]
  localparam logic REG_OUTPUT_SIZE = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_WALK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] compressed_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
  } rsp_t;

endpackage

FILE: rtl/lzw_variable_width_decoder.sv
// LZW decoder, 9 to 13 bit codes packed LSB first.
// Usage: a request on req carries op (feed one compressed byte, or pull one
// decoded byte); each request yields exactly one response on rsp with a
// status and a byte. Both channels use valid/stall; req is accepted when
// req_valid is high and req_stall low, rsp likewise.
// The user must write output_size over APB (byte address 0) only while idle;
// the block does not enforce it. A feed, a finished pull, a needs-input pull
// and a literal after clear answer in the cycle after acceptance. A pull
// served from the string stack is answered from S_POP after one stack read.
// A pull that decodes a code walks in S_WALK, answers from S_FIN; the
// single dictionary read port gives one character per cycle. When the walk
// fills the stack, S_POP reads the top of the stack before the answer.
// One request is in flight at a time; the next is accepted once the
// response register is free or is being taken.
// Reset (synchronous, rst high) clears control state; the dictionary and
// stack memories are not cleared, entries are only read once written.
// A stalled response holds in the output register and blocks new requests.
// Depends on lzwvwd_pkg and lzw_variable_width_decoder_assert.svh.
`include "lzw_variable_width_decoder_assert.svh"
module lzw_variable_width_decoder #(
  parameter int DICT_ENTRIES = lzwvwd_pkg::DICT_ENTRIES_DEF,
  parameter int STACK_DEPTH  = lzwvwd_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  lzwvwd_pkg::req_t   req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output lzwvwd_pkg::rsp_t   rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DA = $clog2(DICT_ENTRIES);
  localparam int SA = $clog2(STACK_DEPTH);
  localparam logic [SA:0] SP_FULL = (SA+1)'(STACK_DEPTH);
  localparam logic [13:0] DICT_LIM = 14'(DICT_ENTRIES);

  lzwvwd_pkg::state_t state, state_next;

  logic [31:0] bits, bits_next;
  logic [5:0]  cnt, cnt_next;
  logic [3:0]  cw, cw_next;
  logic [13:0] nfc, nfc_next;
  logic [13:0] limit, limit_next;
  logic [12:0] prev, prev_next;
  logic [7:0]  fc, fc_next;
  logic [SA:0] sp, sp_next;
  logic [23:0] emitted, emitted_next;
  logic        done, done_next;
  logic [23:0] output_size;
  logic [12:0] cur, cur_next;
  logic [12:0] code_r, code_r_next;
  logic        rd_zero, rd_zero_next;
  logic        rsp_valid_next;
  lzwvwd_pkg::rsp_t rsp_next;

  // Memories and their ports
  logic [20:0]   dict_mem [DICT_ENTRIES];
  logic [7:0]    stk_mem  [STACK_DEPTH];
  logic [20:0]   dict_q;
  logic [7:0]    stk_q;
  logic          dict_re, dict_we, stk_re;
  logic [DA-1:0] dict_raddr, dict_waddr;
  logic [20:0]   dict_wdata;
  logic [SA-1:0] stk_raddr;
  logic          stk_we_w;
  logic [SA-1:0] stk_waddr;
  logic [7:0]    stk_wdata;

  // Shared decode terms
  logic        req_acc, is_done, have_code, clear_ok, kwk, walk0, cont;
  logic        cw_ok;
  logic [13:0] mask14;
  logic [12:0] code_w, cur0, ncur;
  logic [20:0] entry;
  logic [SA:0] sp1;
  logic [13:0] nfc_inc;
  logic [31:0] bits_sh;

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == lzwvwd_pkg::REG_OUTPUT_SIZE) ? {8'd0, output_size} : 32'd0;
  assign req_stall = (state != lzwvwd_pkg::S_IDLE) || (rsp_valid && rsp_stall);
  assign req_acc   = req_valid && !req_stall;

  assign is_done   = done || (emitted >= output_size);
  assign mask14    = (14'd1 << cw) - 14'd1;
  assign code_w    = bits[12:0] & mask14[12:0];
  assign have_code = cnt >= {2'b00, cw};
  assign clear_ok  = {1'b0, cnt} >= ({3'b000, cw} + 7'd9);
  assign kwk       = {1'b0, code_w} >= nfc;
  assign cur0      = kwk ? prev : code_w;
  assign walk0     = cur0 > 13'hFF;
  assign bits_sh   = bits >> cw;

  assign entry     = rd_zero ? 21'd0 : dict_q;
  assign ncur      = entry[20:8];
  assign sp1       = sp + (SA+1)'(1);
  assign cont      = (ncur > 13'hFF) && (sp1 < SP_FULL);
  assign nfc_inc   = (nfc < DICT_LIM) ? nfc + 14'd1 : nfc;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lzwvwd_pkg::S_IDLE: begin
        if (req_acc && req.op == lzwvwd_pkg::OP_PULL && !is_done) begin
          if (sp != '0) begin
            state_next = lzwvwd_pkg::S_POP;
          end else if (have_code && code_w != lzwvwd_pkg::CODE_END &&
                       code_w != lzwvwd_pkg::CODE_CLEAR) begin
            state_next = walk0 ? lzwvwd_pkg::S_WALK : lzwvwd_pkg::S_FIN;
          end
        end
      end
      lzwvwd_pkg::S_POP:  state_next = lzwvwd_pkg::S_IDLE;
      lzwvwd_pkg::S_WALK: state_next = cont ? lzwvwd_pkg::S_WALK : lzwvwd_pkg::S_FIN;
      lzwvwd_pkg::S_FIN:  state_next = (sp < SP_FULL) ? lzwvwd_pkg::S_IDLE : lzwvwd_pkg::S_POP;
      default:            state_next = lzwvwd_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    bits_next      = bits;
    cnt_next       = cnt;
    cw_next        = cw;
    nfc_next       = nfc;
    limit_next     = limit;
    prev_next      = prev;
    fc_next        = fc;
    sp_next        = sp;
    emitted_next   = emitted;
    done_next      = done;
    cur_next       = cur;
    code_r_next    = code_r;
    rd_zero_next   = rd_zero;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    dict_re        = 1'b0;
    dict_raddr     = '0;
    dict_we        = 1'b0;
    dict_waddr     = nfc[DA-1:0];
    dict_wdata     = {prev, fc};
    stk_re         = 1'b0;
    stk_raddr      = '0;
    stk_we_w       = 1'b0;
    stk_waddr      = sp[SA-1:0];
    stk_wdata      = fc;
    case (state)
      lzwvwd_pkg::S_IDLE: begin
        if (req_acc) begin
          if (req.op == lzwvwd_pkg::OP_FEED) begin
            // append byte above the held bits
            rsp_valid_next = 1'b1;
            rsp_next.out_byte = 8'd0;
            if (cnt <= 6'd24) begin
              bits_next = bits | ({24'd0, req.compressed_byte} << cnt);
              cnt_next  = cnt + 6'd8;
              rsp_next.status = lzwvwd_pkg::ST_FED;
            end else begin
              rsp_next.status = lzwvwd_pkg::ST_REFUSED;
            end
          end else if (is_done) begin
            done_next = 1'b1;
            rsp_valid_next = 1'b1;
            rsp_next = '{status: lzwvwd_pkg::ST_DONE, out_byte: 8'd0};
          end else if (sp != '0) begin
            // pop the pending string
            sp_next   = sp - (SA+1)'(1);
            stk_re    = 1'b1;
            stk_raddr = sp_next[SA-1:0];
          end else if (!have_code) begin
            rsp_valid_next = 1'b1;
            rsp_next = '{status: lzwvwd_pkg::ST_NEED, out_byte: 8'd0};
          end else if (code_w == lzwvwd_pkg::CODE_END) begin
            bits_next = bits_sh;
            cnt_next  = cnt - {2'b00, cw};
            done_next = 1'b1;
            rsp_valid_next = 1'b1;
            rsp_next = '{status: lzwvwd_pkg::ST_DONE, out_byte: 8'd0};
          end else if (code_w == lzwvwd_pkg::CODE_CLEAR) begin
            rsp_valid_next = 1'b1;
            if (!clear_ok) begin
              rsp_next = '{status: lzwvwd_pkg::ST_NEED, out_byte: 8'd0};
            end else begin
              // restart widths and take the literal
              bits_next    = bits_sh >> 9;
              cnt_next     = cnt - {2'b00, cw} - 6'd9;
              cw_next      = lzwvwd_pkg::START_WIDTH;
              limit_next   = lzwvwd_pkg::FIRST_LIMIT;
              nfc_next     = lzwvwd_pkg::FIRST_FREE;
              prev_next    = {4'd0, bits_sh[8:0]};
              fc_next      = bits_sh[7:0];
              emitted_next = emitted + 24'd1;
              rsp_next = '{status: lzwvwd_pkg::ST_BYTE, out_byte: bits_sh[7:0]};
            end
          end else begin
            // take the code and start the chain walk
            bits_next   = bits_sh;
            cnt_next    = cnt - {2'b00, cw};
            code_r_next = code_w;
            cur_next    = cur0;
            if (kwk) begin
              stk_we_w  = 1'b1;
              stk_waddr = '0;
              stk_wdata = fc;
              sp_next   = (SA+1)'(1);
            end
            if (walk0) begin
              dict_re      = 1'b1;
              dict_raddr   = cur0[DA-1:0];
              rd_zero_next = {1'b0, cur0} >= DICT_LIM;
            end
          end
        end
      end
      lzwvwd_pkg::S_POP: begin
        rsp_valid_next = 1'b1;
        rsp_next = '{status: lzwvwd_pkg::ST_BYTE, out_byte: stk_q};
        emitted_next = emitted + 24'd1;
      end
      lzwvwd_pkg::S_WALK: begin
        // push this character, follow the prefix
        stk_we_w  = 1'b1;
        stk_waddr = sp[SA-1:0];
        stk_wdata = entry[7:0];
        sp_next   = sp1;
        cur_next  = ncur;
        if (cont) begin
          dict_re      = 1'b1;
          dict_raddr   = ncur[DA-1:0];
          rd_zero_next = {1'b0, ncur} >= DICT_LIM;
        end
      end
      lzwvwd_pkg::S_FIN: begin
        // root byte, new entry, width growth
        fc_next   = cur[7:0];
        prev_next = code_r;
        if (nfc < DICT_LIM) begin
          dict_we    = 1'b1;
          dict_waddr = nfc[DA-1:0];
          dict_wdata = {prev, cur[7:0]};
        end
        nfc_next = nfc_inc;
        if (nfc_inc >= limit && cw < lzwvwd_pkg::MAX_WIDTH) begin
          cw_next    = cw + 4'd1;
          limit_next = limit << 1;
        end
        if (sp < SP_FULL) begin
          // pushed root is popped at once
          rsp_valid_next = 1'b1;
          rsp_next = '{status: lzwvwd_pkg::ST_BYTE, out_byte: cur[7:0]};
          emitted_next = emitted + 24'd1;
        end else begin
          sp_next   = SP_FULL - (SA+1)'(1);
          stk_re    = 1'b1;
          stk_raddr = sp_next[SA-1:0];
        end
      end
      default: begin
        rsp_valid_next = rsp_valid && rsp_stall;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lzwvwd_pkg::S_IDLE;
      bits      <= '0;
      cnt       <= '0;
      cw        <= lzwvwd_pkg::START_WIDTH;
      nfc       <= lzwvwd_pkg::FIRST_FREE;
      limit     <= lzwvwd_pkg::FIRST_LIMIT;
      prev      <= '0;
      fc        <= '0;
      sp        <= '0;
      emitted   <= '0;
      done      <= 1'b0;
      rsp_valid <= 1'b0;
      rd_zero   <= 1'b0;
    end else begin
      state     <= state_next;
      bits      <= bits_next;
      cnt       <= cnt_next;
      cw        <= cw_next;
      nfc       <= nfc_next;
      limit     <= limit_next;
      prev      <= prev_next;
      fc        <= fc_next;
      sp        <= sp_next;
      emitted   <= emitted_next;
      done      <= done_next;
      rsp_valid <= rsp_valid_next;
      rd_zero   <= rd_zero_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur    <= cur_next;
    code_r <= code_r_next;
    rsp    <= rsp_next;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_size <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == lzwvwd_pkg::REG_OUTPUT_SIZE) begin
      output_size <= pwdata[23:0];
    end
  end

  // Dictionary memory
  always_ff @(posedge clk) begin
    if (dict_we) begin
      dict_mem[dict_waddr] <= dict_wdata;
    end
    if (dict_re) begin
      dict_q <= dict_mem[dict_raddr];
    end
  end

  // String stack memory
  always_ff @(posedge clk) begin
    if (stk_we_w) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_raddr];
    end
  end

  // Code width stays within its legal span
  assign cw_ok = (cw >= lzwvwd_pkg::START_WIDTH) && (cw <= lzwvwd_pkg::MAX_WIDTH);

  `LVWD_ASSERT_NOW(a_sp_bound, 1'b1, sp <= SP_FULL, "stack pointer beyond depth")
  `LVWD_ASSERT_NOW(a_width_range, 1'b1, cw_ok, "code width out of range")
  `LVWD_ASSERT_NOW(a_walk_room, state == lzwvwd_pkg::S_WALK, sp < SP_FULL, "chain walk with full stack")
  `LVWD_ASSERT_NEXT(a_pop_answers, state == lzwvwd_pkg::S_POP, rsp_valid && rsp.status == lzwvwd_pkg::ST_BYTE, "stack pop gave no byte")

endmodule

FILE: dv/tb_lzw_variable_width_decoder.sv
// Self-checking testbench for the LZW variable width decoder.
// Builds an LSB-first code stream, predicts every response, checks it in order.
// Depends on lzwvwd_pkg and the lzw_variable_width_decoder RTL.
module tb_lzw_variable_width_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DICT_N      = lzwvwd_pkg::DICT_ENTRIES_DEF;
  localparam int STACK_N     = lzwvwd_pkg::STACK_DEPTH_DEF;
  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE      = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  lzwvwd_pkg::req_t req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  lzwvwd_pkg::rsp_t rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lzw_variable_width_decoder dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pending requests and the responses they must produce
  lzwvwd_pkg::req_t req_pending[$];
  lzwvwd_pkg::rsp_t rsp_expected[$];
  int   err_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_request = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   allow_clear = 1;

  // Decoder shadow state
  logic [31:0] m_buf;
  int          m_cnt, m_width, m_nf, m_limit, m_prev, m_first;
  int          m_dict[DICT_N];
  logic [7:0]  m_stack[STACK_N];
  int          m_sp, m_emitted, m_done, m_osize;

  // Stream encoder state
  logic [63:0] acc;
  int          acc_n, e_nf, e_width, e_limit;
  int          forced_codes[$];

  function automatic int take_code_bits(int w);
    int v;
    v = int'(m_buf & ((32'd1 << w) - 32'd1));
    m_buf = m_buf >> w;
    m_cnt = m_cnt - w;
    return v;
  endfunction

  function automatic void stack_push(int b);
    if (m_sp < STACK_N) begin
      m_stack[m_sp] = b[7:0];
      m_sp++;
    end
  endfunction

  // Expand one code into the string stack and grow the dictionary
  function automatic void expand_code(int code);
    int cur, ent;
    cur = code;
    if (code >= m_nf) begin
      stack_push(m_first);
      cur = m_prev;
    end
    while (cur > 255 && m_sp < STACK_N) begin
      ent = (cur < DICT_N) ? m_dict[cur] : 0;
      stack_push(ent & 255);
      cur = (ent >> 8) & 13'h1FFF;
    end
    m_first = cur & 255;
    stack_push(m_first);
    if (m_nf < DICT_N) begin
      m_dict[m_nf] = ((m_prev & 13'h1FFF) << 8) | m_first;
      m_nf++;
    end
    m_prev = code & 13'h1FFF;
    if (m_nf >= m_limit && m_width < int'(lzwvwd_pkg::MAX_WIDTH)) begin
      m_width++;
      m_limit = m_limit << 1;
    end
  endfunction

  // Predict the response to one request and advance the shadow state
  function automatic lzwvwd_pkg::rsp_t lzw_predict(lzwvwd_pkg::req_t r);
    lzwvwd_pkg::rsp_t e;
    int code, lit;
    e.status = lzwvwd_pkg::ST_BYTE;
    e.out_byte = 8'd0;
    if (r.op == lzwvwd_pkg::OP_FEED) begin
      if (m_cnt <= 24) begin
        m_buf = m_buf | (32'(r.compressed_byte) << m_cnt);
        m_cnt += 8;
        e.status = lzwvwd_pkg::ST_FED;
      end else begin
        e.status = lzwvwd_pkg::ST_REFUSED;
      end
    end else if (m_done != 0 || m_emitted >= m_osize) begin
      m_done = 1;
      e.status = lzwvwd_pkg::ST_DONE;
    end else if (m_sp > 0) begin
      m_sp--;
      e.out_byte = m_stack[m_sp];
      m_emitted++;
    end else if (m_cnt < m_width) begin
      e.status = lzwvwd_pkg::ST_NEED;
    end else begin
      code = int'(m_buf & ((32'd1 << m_width) - 32'd1));
      if (code == int'(lzwvwd_pkg::CODE_END)) begin
        lit = take_code_bits(m_width);
        m_done = 1;
        e.status = lzwvwd_pkg::ST_DONE;
      end else if (code == int'(lzwvwd_pkg::CODE_CLEAR)) begin
        if (m_cnt < m_width + int'(lzwvwd_pkg::START_WIDTH)) begin
          e.status = lzwvwd_pkg::ST_NEED;
        end else begin
          lit = take_code_bits(m_width);
          m_width = int'(lzwvwd_pkg::START_WIDTH);
          m_limit = int'(lzwvwd_pkg::FIRST_LIMIT);
          m_nf = int'(lzwvwd_pkg::FIRST_FREE);
          lit = take_code_bits(int'(lzwvwd_pkg::START_WIDTH));
          m_prev = lit;
          m_first = lit & 255;
          e.out_byte = m_first[7:0];
          m_emitted++;
        end
      end else begin
        lit = take_code_bits(m_width);
        expand_code(code);
        m_sp--;
        e.out_byte = m_stack[m_sp];
        m_emitted++;
      end
    end
    return e;
  endfunction

  function automatic void add_bits(int v, int w);
    acc = acc | (64'(v) << acc_n);
    acc_n += w;
  endfunction

  // Append one well-formed code (clear brings its literal along)
  function automatic void gen_code(int lit_pct);
    int c, r, lit;
    if (forced_codes.size() > 0) begin
      c = forced_codes.pop_front();
    end else begin
      r = $urandom_range(99);
      if (r < 1 && allow_clear != 0) c = int'(lzwvwd_pkg::CODE_CLEAR);
      else if (r < lit_pct) c = $urandom_range(255);
      else if (e_nf > int'(lzwvwd_pkg::FIRST_FREE) && r < 92)
        c = $urandom_range(e_nf - 1, int'(lzwvwd_pkg::FIRST_FREE));
      else if (e_nf < DICT_N) c = e_nf;
      else c = $urandom_range(255);
    end
    add_bits(c, e_width);
    if (c == int'(lzwvwd_pkg::CODE_CLEAR)) begin
      e_width = int'(lzwvwd_pkg::START_WIDTH);
      e_nf = int'(lzwvwd_pkg::FIRST_FREE);
      e_limit = int'(lzwvwd_pkg::FIRST_LIMIT);
      lit = (forced_codes.size() > 0) ? forced_codes.pop_front() : $urandom_range(255);
      add_bits(lit, int'(lzwvwd_pkg::START_WIDTH));
    end else if (c != int'(lzwvwd_pkg::CODE_END)) begin
      if (e_nf < DICT_N) e_nf++;
      if (e_nf >= e_limit && e_width < int'(lzwvwd_pkg::MAX_WIDTH)) begin
        e_width++;
        e_limit = e_limit << 1;
      end
    end
  endfunction

  function automatic logic [7:0] next_stream_byte(int lit_pct);
    logic [7:0] b;
    while (acc_n < 8) gen_code(lit_pct);
    b = acc[7:0];
    acc = acc >> 8;
    acc_n -= 8;
    return b;
  endfunction

  function automatic void queue_request(lzwvwd_pkg::req_t r);
    req_pending.push_back(r);
    rsp_expected.push_back(lzw_predict(r));
  endfunction

  // Choose one request from the shadow state: mostly a clean stream, some noise
  function automatic void plan_one(int lit_pct);
    lzwvwd_pkg::req_t r;
    int   roll;
    bit   can_decode;
    roll = $urandom_range(99);
    can_decode = (m_sp > 0) || (m_cnt >= m_width);
    r.compressed_byte = $urandom_range(255);
    if (m_cnt > 24 && roll < 8) begin
      r.op = lzwvwd_pkg::OP_FEED;
    end else if (!can_decode && roll < 3) begin
      r.op = lzwvwd_pkg::OP_PULL;
    end else if (can_decode && (m_cnt > 24 || roll < 55)) begin
      r.op = lzwvwd_pkg::OP_PULL;
    end else if (m_cnt <= 24) begin
      r.op = lzwvwd_pkg::OP_FEED;
      r.compressed_byte = next_stream_byte(lit_pct);
    end else begin
      r.op = lzwvwd_pkg::OP_PULL;
    end
    queue_request(r);
  endfunction

  task automatic plan_items(int n, int lit_pct, bit until_full);
    int k;
    k = 0;
    while (k < n || (until_full && m_nf < DICT_N)) begin
      plan_one(lit_pct);
      k++;
    end
  endtask

  task automatic wait_drained();
    while (req_pending.size() > 0 || rsp_expected.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, logic [31:0] data, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {lzwvwd_pkg::REG_OUTPUT_SIZE, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_output_size(int value);
    logic [31:0] rd;
    apb_access(1'b1, 32'(value), rd);
    m_osize = value & 24'hFFFFFF;
    apb_access(1'b0, 32'd0, rd);
    if (rd[23:0] !== m_osize[23:0])
      $error("output_size readback: expected %0d, got %0d", m_osize, rd[23:0]);
  endtask

  // Driver: hold a stalled request, advance on acceptance, idle at random
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      void'(req_pending.pop_front());
      if (req_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_valid <= 1'b1;
        req <= req_pending[0];
      end else begin
        req_valid <= 1'b0;
      end
    end else if (!req_valid && req_pending.size() > 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      req_valid <= 1'b1;
      req <= req_pending[0];
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: compare each accepted response with the oldest expectation
  always @(posedge clk) begin
    lzwvwd_pkg::rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_expected.size() == 0) begin
        $error("response with nothing expected: status %0d byte %0d", rsp.status, rsp.out_byte);
        err_count++;
      end else begin
        exp_rsp = rsp_expected.pop_front();
        if (rsp.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
          err_count++;
        end
        if (rsp.out_byte !== exp_rsp.out_byte) begin
          $error("out_byte: expected %0d, got %0d", exp_rsp.out_byte, rsp.out_byte);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run when busy with no handshake for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (req_pending.size() == 0 && rsp_expected.size() == 0))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    lzwvwd_pkg::req_t r;
    int k;
    m_buf = '0; m_cnt = 0; m_width = int'(lzwvwd_pkg::START_WIDTH);
    m_nf = int'(lzwvwd_pkg::FIRST_FREE);
    m_limit = int'(lzwvwd_pkg::FIRST_LIMIT); m_prev = 0; m_first = 0; m_sp = 0;
    m_emitted = 0; m_done = 0; m_osize = 0;
    acc = '0; acc_n = 0; e_nf = int'(lzwvwd_pkg::FIRST_FREE);
    e_width = int'(lzwvwd_pkg::START_WIDTH); e_limit = int'(lzwvwd_pkg::FIRST_LIMIT);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: starved pull, literals 0 and 255, KwKwK, known entry, clear + literal
    set_output_size(24'hFFFFFF);
    forced_codes = '{0, 255, 260, 258, int'(lzwvwd_pkg::CODE_CLEAR), 255, 258};
    r.op = lzwvwd_pkg::OP_PULL;
    r.compressed_byte = 8'h00;
    queue_request(r);
    while (m_cnt <= 24) begin
      r.op = lzwvwd_pkg::OP_FEED;
      r.compressed_byte = next_stream_byte(50);
      queue_request(r);
    end
    r.op = lzwvwd_pkg::OP_FEED;
    r.compressed_byte = 8'hFF;
    queue_request(r);
    r.compressed_byte = 8'h00;
    queue_request(r);
    plan_items(16, 50, 1'b0);
    wait_drained();

    // Random stream, no idling
    plan_items(200, 50, 1'b0);
    wait_drained();

    // Sender idles half the time
    set_output_size(100000);
    send_idle_pct = 50;
    plan_items(200, 50, 1'b0);
    wait_drained();

    // Receiver stalls half the time, after a long hold-off that backs up the input
    send_idle_pct = 0;
    stall_pct = 50;
    hold_request = 300;
    plan_items(200, 50, 1'b0);
    wait_drained();

    // Both sides idle
    send_idle_pct = 22;
    stall_pct = 22;
    plan_items(200, 50, 1'b0);
    wait_drained();

    // Clear-free stretch of mostly literals so the dictionary and code width grow
    send_idle_pct = 0;
    stall_pct = 0;
    allow_clear = 0;
    set_output_size(24'hFFFFFF);
    plan_items(250, 85, 1'b0);
    wait_drained();
    allow_clear = 1;

    // End of stream, then pulls report finished and feeds still work
    send_idle_pct = 22;
    stall_pct = 22;
    forced_codes.push_back(int'(lzwvwd_pkg::CODE_END));
    k = 0;
    while (m_done == 0 && k < 20000) begin
      plan_one(50);
      k++;
    end
    plan_items(8, 50, 1'b0);
    wait_drained();

    set_output_size(0);
    plan_items(8, 50, 1'b0);
    wait_drained();

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
